// ===== hdl/owbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the 1-Wire bus master: command and result
// transaction payloads, command codes and timing register indexes.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned TIMER_BITS_DEF    = 16;
  localparam int unsigned MAX_READ_BITS_DEF = 64;

  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned REG_IDX_W     = 3;
  localparam int unsigned RX_DATA_W     = 64;
  localparam int unsigned READ_CNT_W    = 7;
  localparam int unsigned BITS_PER_BYTE = 8;

  // command codes
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // timing register indexes
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRES_SAMP  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PRES_HOLD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_W1_LOW     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SLOT       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RD_LOW     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY   = 3'd7;

  // register reset values, same order as the indexes above
  localparam logic [CFG_DATA_W-1:0] RESET_LOW_DEF  = 16'd34560;
  localparam logic [CFG_DATA_W-1:0] PRES_SAMP_DEF  = 16'd4320;
  localparam logic [CFG_DATA_W-1:0] PRES_HOLD_DEF  = 16'd30240;
  localparam logic [CFG_DATA_W-1:0] W1_LOW_DEF     = 16'd1080;
  localparam logic [CFG_DATA_W-1:0] SLOT_DEF       = 16'd4320;
  localparam logic [CFG_DATA_W-1:0] RD_LOW_DEF     = 16'd72;
  localparam logic [CFG_DATA_W-1:0] RD_SAMPLE_DEF  = 16'd864;
  localparam logic [CFG_DATA_W-1:0] RECOVERY_DEF   = 16'd72;

  typedef struct packed {
    logic [1:0]            func;
    logic [7:0]            tx_byte;
    logic [READ_CNT_W-1:0] read_count;
    logic                  line_level;
  } cmd_t;

  typedef struct packed {
    logic                 drive_low;
    logic                 busy_res;
    logic                 done_res;
    logic                 presence;
    logic [RX_DATA_W-1:0] rx_data;
  } res_t;

endpackage

// ===== hdl/one_wire_bus_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped once per tick: reset/presence, byte write and
// multi-bit read sequences driven by eight programmable timing registers.
// ----------------------------------------------------------------------------
// Each command transaction is one timer tick: it carries an optional command
// (none, reset with presence detect, write byte, read 1..MAX_READ_BITS bits)
// and the bus level sampled on that tick. The block takes one transaction
// every clock cycle while cmd_stall is low and returns exactly one result
// transaction for it from a result register backed by a one-entry skid
// stage; the command side stalls only while that skid stage is full, so it
// is held while a result stall lasts and runs back to back otherwise. The
// sequencer state advances by one step per accepted transaction, so bus
// timing is counted in accepted transactions, not clock cycles. Commands
// that arrive while a sequence runs, including on the tick it completes, are
// dropped. The eight timing registers are written through the cfg port
// (always ready); the user must write them only while the block is idle,
// which the block itself does not enforce. Values are truncated to TIMER_BITS,
// and a zero in any register except recovery acts as one. rx_data holds the
// bits of the last read, first bit in bit 0, filled live as the read progresses.
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int unsigned MAX_READ_BITS = MAX_READ_BITS_DEF,  // 8..64
  parameter int unsigned TIMER_BITS    = TIMER_BITS_DEF      // 8..32
) (
  input  logic                  clk,
  input  logic                  rst,
  // command transactions
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd_data,
  // result transactions
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res_data,
  // timing register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // bit counter must hold both MAX_READ_BITS and a full byte
  localparam int unsigned BIT_W = $clog2(MAX_READ_BITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_READ_BITS);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_HOLD,
    PH_WR_SLOT,
    PH_WR_REC,
    PH_RD_SLOT,
    PH_RD_REC
  } phase_t;

  // --------------------------------------------------------------------------
  // Timing registers
  // --------------------------------------------------------------------------
  logic [TIMER_BITS-1:0] cfg_regs [NUM_REGS];
  logic [TIMER_BITS-1:0] t_eff    [NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[REG_RESET_LOW] <= TIMER_BITS'(RESET_LOW_DEF);
      cfg_regs[REG_PRES_SAMP] <= TIMER_BITS'(PRES_SAMP_DEF);
      cfg_regs[REG_PRES_HOLD] <= TIMER_BITS'(PRES_HOLD_DEF);
      cfg_regs[REG_W1_LOW]    <= TIMER_BITS'(W1_LOW_DEF);
      cfg_regs[REG_SLOT]      <= TIMER_BITS'(SLOT_DEF);
      cfg_regs[REG_RD_LOW]    <= TIMER_BITS'(RD_LOW_DEF);
      cfg_regs[REG_RD_SAMPLE] <= TIMER_BITS'(RD_SAMPLE_DEF);
      cfg_regs[REG_RECOVERY]  <= TIMER_BITS'(RECOVERY_DEF);
    end else if (cfg_valid && cfg_ready) begin
      cfg_regs[cfg_index] <= TIMER_BITS'(cfg_data);
    end
  end

  // zero means one, except recovery where zero skips the gap
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (i != int'(REG_RECOVERY) && cfg_regs[i] == '0) begin
        t_eff[i] = TIMER_BITS'(1);
      end else begin
        t_eff[i] = cfg_regs[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  phase_t                   phase, phase_next;
  logic [TIMER_BITS-1:0]    tick_count, tick_next, tick_inc;
  logic [BIT_W-1:0]         bit_index, bit_next;
  logic [BIT_W-1:0]         bits_wanted, wanted_next;
  logic [7:0]               send_shift, send_next;
  logic [MAX_READ_BITS-1:0] receive_shift, recv_next;
  logic                     presence_flag, pres_next;
  logic                     done_next;
  logic                     drive_next;
  logic [READ_CNT_W-1:0]    read_n;
  res_t                     res_next;

  logic cmd_fire, res_fire;
  res_t skid_data;
  logic skid_valid;

  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign res_fire  = res_valid && !res_stall;
  assign cmd_stall = skid_valid;

  // clamp of the requested read length
  always_comb begin
    if (cmd_data.read_count == '0) begin
      read_n = READ_CNT_W'(1);
    end else if (cmd_data.read_count > READ_CNT_W'(MAX_READ_BITS)) begin
      read_n = READ_CNT_W'(MAX_READ_BITS);
    end else begin
      read_n = cmd_data.read_count;
    end
  end

  // one tick of the sequencer
  always_comb begin
    phase_next  = phase;
    tick_next   = tick_count;
    bit_next    = bit_index;
    wanted_next = bits_wanted;
    send_next   = send_shift;
    recv_next   = receive_shift;
    pres_next   = presence_flag;
    done_next   = 1'b0;
    tick_inc    = tick_count + 1'b1;

    case (phase)
      PH_IDLE: begin
        case (cmd_data.func)
          FUNC_RESET: begin
            phase_next = PH_RST_LOW;
            tick_next  = '0;
          end
          FUNC_WRITE: begin
            send_next  = cmd_data.tx_byte;
            bit_next   = '0;
            phase_next = PH_WR_SLOT;
            tick_next  = '0;
          end
          FUNC_READ: begin
            wanted_next = BIT_W'(read_n);
            bit_next    = '0;
            recv_next   = '0;
            phase_next  = PH_RD_SLOT;
            tick_next   = '0;
          end
          default: begin
          end
        endcase
      end
      PH_RST_LOW: begin
        tick_next = tick_inc;
        if (tick_inc >= t_eff[REG_RESET_LOW]) begin
          phase_next = PH_RST_WAIT;
          tick_next  = '0;
        end
      end
      PH_RST_WAIT: begin
        tick_next = tick_inc;
        if (tick_inc >= t_eff[REG_PRES_SAMP]) begin
          pres_next  = !cmd_data.line_level;  // device pulls low
          phase_next = PH_RST_HOLD;
          tick_next  = '0;
        end
      end
      PH_RST_HOLD: begin
        tick_next = tick_inc;
        if (tick_inc >= t_eff[REG_PRES_HOLD]) begin
          phase_next = PH_IDLE;
          done_next  = 1'b1;
        end
      end
      PH_WR_SLOT: begin
        tick_next = tick_inc;
        if (tick_inc >= t_eff[REG_SLOT]) begin
          send_next = send_shift >> 1;
          bit_next  = bit_index + 1'b1;
          tick_next = '0;
          if (t_eff[REG_RECOVERY] != '0) begin
            phase_next = PH_WR_REC;
          end else if (bit_next >= BIT_W'(BITS_PER_BYTE)) begin
            phase_next = PH_IDLE;
            tick_next  = tick_inc;
            done_next  = 1'b1;
          end
        end
      end
      PH_WR_REC: begin
        tick_next = tick_inc;
        if (tick_inc >= t_eff[REG_RECOVERY]) begin
          if (bit_index >= BIT_W'(BITS_PER_BYTE)) begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end else begin
            phase_next = PH_WR_SLOT;
            tick_next  = '0;
          end
        end
      end
      PH_RD_SLOT: begin
        tick_next = tick_inc;
        if (tick_inc == t_eff[REG_RD_SAMPLE]) begin
          recv_next[bit_index[IDX_W-1:0]] =
            receive_shift[bit_index[IDX_W-1:0]] | cmd_data.line_level;
        end
        if (tick_inc >= t_eff[REG_SLOT] && tick_inc >= t_eff[REG_RD_SAMPLE]) begin
          bit_next  = bit_index + 1'b1;
          tick_next = '0;
          if (t_eff[REG_RECOVERY] != '0) begin
            phase_next = PH_RD_REC;
          end else if (bit_next >= bits_wanted) begin
            phase_next = PH_IDLE;
            tick_next  = tick_inc;
            done_next  = 1'b1;
          end
        end
      end
      PH_RD_REC: begin
        tick_next = tick_inc;
        if (tick_inc >= t_eff[REG_RECOVERY]) begin
          if (bit_index >= bits_wanted) begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end else begin
            phase_next = PH_RD_SLOT;
            tick_next  = '0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        tick_next  = tick_inc;
      end
    endcase

    // line drive for the new state
    case (phase_next)
      PH_RST_LOW: drive_next = 1'b1;
      PH_WR_SLOT: drive_next = tick_next < (send_next[0] ? t_eff[REG_W1_LOW]
                                                          : t_eff[REG_SLOT]);
      PH_RD_SLOT: drive_next = tick_next < t_eff[REG_RD_LOW];
      default:    drive_next = 1'b0;
    endcase

    res_next.drive_low = drive_next;
    res_next.busy_res  = (phase_next != PH_IDLE);
    res_next.done_res  = done_next;
    res_next.presence  = pres_next;
    res_next.rx_data   = RX_DATA_W'(recv_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      bits_wanted   <= '0;
      send_shift    <= '0;
      receive_shift <= '0;
      presence_flag <= 1'b0;
    end else if (cmd_fire) begin
      phase         <= phase_next;
      tick_count    <= tick_next;
      bit_index     <= bit_next;
      bits_wanted   <= wanted_next;
      send_shift    <= send_next;
      receive_shift <= recv_next;
      presence_flag <= pres_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register with one-entry skid stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no command taken while the skid entry is full
      if (res_fire) begin
        res_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (cmd_fire) begin
      if (!res_valid || res_fire) begin
        res_data  <= res_next;
        res_valid <= 1'b1;
      end else begin
        skid_data  <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (res_fire) begin
      res_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held with empty result register");

  a_cmd_gives_res: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> res_valid)
    else $error("accepted command produced no result");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.done_res) |-> (!res_data.busy_res && !res_data.drive_low))
    else $error("done tick with line driven or busy");

  a_wr_bits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WR_SLOT) |-> (bit_index < BIT_W'(BITS_PER_BYTE)))
    else $error("write slot past last bit");

  a_rd_bits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RD_SLOT) |-> (bit_index < bits_wanted))
    else $error("read slot past requested count");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for one_wire_bus_master
// Drives one bus tick per command transaction, predicts every result
// transaction with a tick-exact model of the sequencer, compares field by
// field. Directed table first, then random traffic over several short timing
// sets; the table covers the all-zero and wide low-time extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import owbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned DRAIN_CYCLES = 8;          // result reg + skid, with margin
  localparam int unsigned RANDOM_TICKS = 60;         // per random timing set
  localparam int unsigned REPORT_CAP   = 200;        // keep a broken run's log readable

  // sequencer phases of the prediction model
  typedef enum logic [3:0] {
    ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_HOLD,
    ST_WR_SLOT, ST_WR_REC, ST_RD_SLOT, ST_RD_REC
  } seq_phase_e;

  typedef struct {
    seq_phase_e   phase;
    int unsigned  ticks;      // ticks into the current phase
    int unsigned  bit_idx;
    int unsigned  bits_want;
    logic [7:0]   tx_shift;
    logic [63:0]  rx_shift;
    logic         pres;
  } bus_state_t;

  // how the sender/receiver idle: a random gap before every item, never, or now and then
  typedef enum logic [1:0] {IDLE_FULL, IDLE_OFF, IDLE_SPARSE} idle_mode_e;

  // directed table: a row is a register write or a command plus what follows it
  typedef enum logic [1:0] {ROW_CFG, ROW_CMD} row_kind_e;
  typedef enum logic [1:0] {
    RUN_OUT,      // idle ticks until the sequence is over
    RUN_NONE,     // next row lands while still busy
    RUN_TO_DONE   // next row lands on the completion tick
  } row_tail_e;

  typedef struct {
    row_kind_e              kind;
    logic [REG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    cmd_t                   cmd;
    row_tail_e              tail;
    logic                   typed;  // want holds a hand-written result
    res_t                   want;
  } table_row_t;

  localparam res_t IDLE_RES        = '0;
  localparam res_t RESET_START_RES = {1'b1, 1'b1, 1'b0, 1'b0, 64'd0};

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_t                  cmd_data  = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  one_wire_bus_master uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] timing_regs [NUM_REGS];   // model copy of the registers
  logic [CFG_DATA_W-1:0] reg_defaults [NUM_REGS] = '{
    RESET_LOW_DEF, PRES_SAMP_DEF, PRES_HOLD_DEF, W1_LOW_DEF,
    SLOT_DEF, RD_LOW_DEF, RD_SAMPLE_DEF, RECOVERY_DEF
  };
  bus_state_t  bus;                    // model sequencer state
  res_t        bus_results_due [$];    // results owed by the DUT, oldest first
  table_row_t  directed_rows [$];
  idle_mode_e  idle_mode = IDLE_FULL;

  int unsigned cycles          = 0;
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_sent      = 0;
  int unsigned resets_run      = 0;
  int unsigned writes_run      = 0;
  int unsigned reads_run       = 0;
  int unsigned stall_left      = 0;
  int unsigned res_gap;
  res_t        due_res;

  // --------------------------------------------------------------------------
  // Prediction model
  // --------------------------------------------------------------------------

  // zero in any timing register but recovery behaves as one
  function automatic int unsigned eff(input logic [REG_IDX_W-1:0] idx);
    int unsigned v;
    v = timing_regs[idx];
    if (idx != REG_RECOVERY && v == 0) v = 1;
    return v;
  endfunction

  // after a slot (and its recovery): next bit, or finished
  function automatic logic next_bit(inout bus_state_t s, input int unsigned limit,
                                    input seq_phase_e slot_ph);
    if (s.bit_idx >= limit) begin
      s.phase = ST_IDLE;
      return 1'b1;
    end
    s.phase = slot_ph;
    s.ticks = 0;
    return 1'b0;
  endfunction

  // one bus tick: update the state, return the result transaction it yields
  function automatic res_t next_bus_tick(inout bus_state_t s, input cmd_t c);
    res_t        r;
    logic        fin;
    int unsigned n;
    fin = 1'b0;
    if (s.phase == ST_IDLE) begin
      case (c.func)
        FUNC_RESET: begin
          s.phase = ST_RST_LOW;
          s.ticks = 0;
        end
        FUNC_WRITE: begin
          s.tx_shift = c.tx_byte;
          s.bit_idx  = 0;
          s.phase    = ST_WR_SLOT;
          s.ticks    = 0;
        end
        FUNC_READ: begin
          n = c.read_count;
          if (n == 0) n = 1;
          if (n > MAX_READ_BITS_DEF) n = MAX_READ_BITS_DEF;
          s.bits_want = n;
          s.bit_idx   = 0;
          s.rx_shift  = '0;
          s.phase     = ST_RD_SLOT;
          s.ticks     = 0;
        end
        default: ;
      endcase
    end else begin
      // busy: any command on this tick is dropped
      s.ticks++;
      case (s.phase)
        ST_RST_LOW:
          if (s.ticks >= eff(REG_RESET_LOW)) begin
            s.phase = ST_RST_WAIT;
            s.ticks = 0;
          end
        ST_RST_WAIT:
          if (s.ticks >= eff(REG_PRES_SAMP)) begin
            s.pres  = ~c.line_level;   // a device pulls the line low
            s.phase = ST_RST_HOLD;
            s.ticks = 0;
          end
        ST_RST_HOLD:
          if (s.ticks >= eff(REG_PRES_HOLD)) begin
            s.phase = ST_IDLE;
            fin     = 1'b1;
          end
        ST_WR_SLOT:
          if (s.ticks >= eff(REG_SLOT)) begin
            s.tx_shift = s.tx_shift >> 1;
            s.bit_idx++;
            if (eff(REG_RECOVERY) > 0) begin
              s.phase = ST_WR_REC;
              s.ticks = 0;
            end else begin
              fin = next_bit(s, BITS_PER_BYTE, ST_WR_SLOT);
            end
          end
        ST_WR_REC:
          if (s.ticks >= eff(REG_RECOVERY)) fin = next_bit(s, BITS_PER_BYTE, ST_WR_SLOT);
        ST_RD_SLOT: begin
          if (s.ticks == eff(REG_RD_SAMPLE) && s.bit_idx < RX_DATA_W)
            s.rx_shift = s.rx_shift | (64'(c.line_level) << s.bit_idx);
          // slot runs until both the slot length and the sample point are reached
          if (s.ticks >= eff(REG_SLOT) && s.ticks >= eff(REG_RD_SAMPLE)) begin
            s.bit_idx++;
            if (eff(REG_RECOVERY) > 0) begin
              s.phase = ST_RD_REC;
              s.ticks = 0;
            end else begin
              fin = next_bit(s, s.bits_want, ST_RD_SLOT);
            end
          end
        end
        ST_RD_REC:
          if (s.ticks >= eff(REG_RECOVERY)) fin = next_bit(s, s.bits_want, ST_RD_SLOT);
        default: s.phase = ST_IDLE;
      endcase
    end

    case (s.phase)
      ST_RST_LOW: r.drive_low = 1'b1;
      ST_WR_SLOT: r.drive_low = s.ticks < (s.tx_shift[0] ? eff(REG_W1_LOW) : eff(REG_SLOT));
      ST_RD_SLOT: r.drive_low = s.ticks < eff(REG_RD_LOW);
      default:    r.drive_low = 1'b0;
    endcase
    r.busy_res = (s.phase != ST_IDLE);
    r.done_res = fin;
    r.presence = s.pres;
    r.rx_data  = s.rx_shift;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    case (idle_mode)
      IDLE_OFF:    return 0;
      IDLE_SPARSE: return ($urandom_range(0, 31) == 0) ? $urandom_range(0, 7) : 0;
      default:     return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic table_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    table_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.val   = val;
    row.cmd   = '0;
    row.tail  = RUN_OUT;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic table_row_t cmd_row(input logic [1:0] f, input logic [7:0] tx,
                                         input logic [6:0] cnt, input logic line,
                                         input row_tail_e tail, input logic typed = 1'b0,
                                         input res_t want = '0);
    table_row_t row;
    row.kind  = ROW_CMD;
    row.idx   = '0;
    row.val   = '0;
    row.cmd   = {f, tx, cnt, line};
    row.tail  = tail;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // one command transaction (one bus tick); the model steps when it is taken
  task automatic send_tick(input cmd_t c, input logic typed, input res_t want);
    int unsigned gap;
    res_t        r;
    gap = draw_gap();
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (cmd_stall);
    if (bus.phase == ST_IDLE) begin
      case (c.func)
        FUNC_RESET: resets_run++;
        FUNC_WRITE: writes_run++;
        FUNC_READ:  reads_run++;
        default: ;
      endcase
    end
    r = next_bus_tick(bus, c);
    bus_results_due.push_back(typed ? want : r);
    ticks_sent++;
  endtask

  // a command followed by idle ticks, as the tail asks
  task automatic run_command(input cmd_t c, input row_tail_e tail, input logic typed,
                             input res_t want, input logic rand_line);
    cmd_t       fill;
    bus_state_t probe;
    res_t       peek;
    send_tick(c, typed, want);
    fill      = c;
    fill.func = FUNC_NONE;
    forever begin
      if (tail == RUN_NONE || bus.phase == ST_IDLE) break;
      if (tail == RUN_TO_DONE) begin
        probe = bus;
        peek  = next_bus_tick(probe, fill);
        if (peek.done_res) break;
      end
      if (rand_line) fill.line_level = 1'($urandom_range(0, 1));
      send_tick(fill, 1'b0, '0);
    end
  endtask

  // stop sending and let every owed result come back
  task automatic settle();
    cmd_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays up for back-to-back writes; caller lowers it
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    timing_regs[idx] = val;
  endtask

  // random traffic over one random timing set, ends with the sequencer idle
  task automatic run_random_phase(input int unsigned quota, input int unsigned span);
    cmd_t        c;
    int unsigned k;
    int unsigned sel;
    settle();
    for (k = 0; k < NUM_REGS; k++)
      write_reg(REG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, span)));
    cfg_valid <= 1'b0;
    for (k = 0; k < quota || bus.phase != ST_IDLE; k++) begin
      if (k % 64 == 0) idle_mode <= ($urandom_range(0, 3) == 0) ? IDLE_OFF : IDLE_FULL;
      c.tx_byte    = 8'($urandom_range(0, 255));
      c.read_count = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(1, 12));
      c.line_level = 1'($urandom_range(0, 1));
      sel          = $urandom_range(0, 9);
      if (k >= quota)
        c.func = FUNC_NONE;                           // draining out
      else if (bus.phase == ST_IDLE)
        c.func = (sel == 0) ? FUNC_NONE  :
                 (sel < 4)  ? FUNC_RESET :
                 (sel < 7)  ? FUNC_WRITE : FUNC_READ;
      else
        c.func = (sel == 0) ? 2'($urandom_range(1, 3)) : FUNC_NONE;  // dropped noise
      send_tick(c, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall after each result, then compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (res_stall) begin
      if (stall_left == 0) res_stall <= 1'b0;
      else stall_left <= stall_left - 1;
    end else if (res_valid) begin
      res_gap = draw_gap();
      if (res_gap != 0) begin
        res_stall  <= 1'b1;
        stall_left <= res_gap - 1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (bus_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, got %h", $time, res_data);
      end else begin
        due_res = bus_results_due.pop_front();
        check_field("drive_low", 64'(due_res.drive_low), 64'(res_data.drive_low));
        check_field("busy_res",  64'(due_res.busy_res),  64'(res_data.busy_res));
        check_field("done_res",  64'(due_res.done_res),  64'(res_data.done_res));
        check_field("presence",  64'(due_res.presence),  64'(res_data.presence));
        check_field("rx_data",   due_res.rx_data,        res_data.rx_data);
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned k;
    int unsigned i;
    int unsigned spans [6];

    for (k = 0; k < NUM_REGS; k++) timing_regs[k] = reg_defaults[k];
    bus    = '{ST_IDLE, 0, 0, 0, 8'h00, 64'd0, 1'b0};
    spans  = '{3, 2, 8, 5, 20, 4};

    // short timing set so every sequence finishes in a handful of ticks
    directed_rows.push_back(cfg_row(REG_RESET_LOW, 16'd3));
    directed_rows.push_back(cfg_row(REG_PRES_SAMP, 16'd2));
    directed_rows.push_back(cfg_row(REG_PRES_HOLD, 16'd2));
    directed_rows.push_back(cfg_row(REG_W1_LOW,    16'd1));
    directed_rows.push_back(cfg_row(REG_SLOT,      16'd3));
    directed_rows.push_back(cfg_row(REG_RD_LOW,    16'd1));
    directed_rows.push_back(cfg_row(REG_RD_SAMPLE, 16'd2));
    directed_rows.push_back(cfg_row(REG_RECOVERY,  16'd1));
    // idle ticks straight after reset, all fields low then all high
    directed_rows.push_back(cmd_row(FUNC_NONE,  8'h00, 7'd0,   1'b0, RUN_NONE, 1'b1, IDLE_RES));
    directed_rows.push_back(cmd_row(FUNC_NONE,  8'hFF, 7'd127, 1'b1, RUN_NONE, 1'b1, IDLE_RES));
    // reset with a device present, then with none
    directed_rows.push_back(cmd_row(FUNC_RESET, 8'h00, 7'd0, 1'b0, RUN_OUT, 1'b1,
                                    RESET_START_RES));
    directed_rows.push_back(cmd_row(FUNC_RESET, 8'h00, 7'd0, 1'b1, RUN_OUT));
    // a write that lands on the completion tick is dropped
    directed_rows.push_back(cmd_row(FUNC_RESET, 8'h00, 7'd0, 1'b0, RUN_TO_DONE));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'hA5, 7'd0, 1'b0, RUN_NONE));
    // all write-zero slots, then all write-one slots
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'h00, 7'd0, 1'b1, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'hFF, 7'd0, 1'b1, RUN_OUT));
    // commands while a read runs are dropped
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd8, 1'b1, RUN_NONE));
    directed_rows.push_back(cmd_row(FUNC_RESET, 8'h00, 7'd0, 1'b1, RUN_NONE));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'h3C, 7'd0, 1'b1, RUN_OUT));
    // read count of zero acts as one; above the max saturates
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd0,   1'b0, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd127, 1'b1, RUN_OUT));
    // receive register survives reset and write
    directed_rows.push_back(cmd_row(FUNC_RESET, 8'h00, 7'd0, 1'b1, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'h5A, 7'd0, 1'b0, RUN_OUT));
    // full-width read, then a read on its completion tick
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd64, 1'b0, RUN_TO_DONE));
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd1,  1'b1, RUN_NONE));
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd65, 1'b1, RUN_OUT));
    // all registers zero: timings act as one, recovery gap skipped
    for (k = 0; k < NUM_REGS; k++) directed_rows.push_back(cfg_row(REG_IDX_W'(k), 16'd0));
    directed_rows.push_back(cmd_row(FUNC_RESET, 8'h00, 7'd0, 1'b0, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'h96, 7'd0, 1'b0, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd5, 1'b1, RUN_OUT));
    // low times past the slot end, sample point past the slot end
    directed_rows.push_back(cfg_row(REG_W1_LOW,    16'hFFFF));
    directed_rows.push_back(cfg_row(REG_SLOT,      16'd2));
    directed_rows.push_back(cfg_row(REG_RD_LOW,    16'hFFFF));
    directed_rows.push_back(cfg_row(REG_RD_SAMPLE, 16'd5));
    directed_rows.push_back(cfg_row(REG_RECOVERY,  16'd3));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'hFF, 7'd0, 1'b0, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_WRITE, 8'h01, 7'd0, 1'b0, RUN_OUT));
    directed_rows.push_back(cmd_row(FUNC_READ,  8'h00, 7'd3, 1'b1, RUN_OUT));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table; registers only change once the sequencer is idle
    for (i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CFG) settle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        run_command(directed_rows[i].cmd, directed_rows[i].tail, directed_rows[i].typed,
                    directed_rows[i].want, 1'b0);
      end
    end

    // random traffic over several short timing sets
    for (i = 0; i < 6; i++) run_random_phase(RANDOM_TICKS, spans[i]);

    settle();
    $display("Sent %0d bus ticks: %0d resets, %0d byte writes, %0d reads; %0d results checked.",
             ticks_sent, resets_run, writes_run, reads_run, results_checked);
    $display("Timing sets: short directed, all zero, wide low times, random short; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/owbm_pkg.sv
hdl/one_wire_bus_master.sv
bench/tb_top.sv
